>>> hw/rtl/pin_entry_lock_with_lockout_macros.svh
// ----------------------------------------------------------------------------
// PIN entry lock assertion macros
// Shared concurrent assertion forms, clocked on aclk and quiet in reset.
// ----------------------------------------------------------------------------
`ifndef PIN_ENTRY_LOCK_WITH_LOCKOUT_MACROS_SVH
`define PIN_ENTRY_LOCK_WITH_LOCKOUT_MACROS_SVH

// Same-cycle implication.
`define PEL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the next cycle.
`define PEL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/pel_pkg.sv
// ----------------------------------------------------------------------------
// PIN entry lock package
// Types, codes, timing constants and register reset values of the lock.
// ----------------------------------------------------------------------------
package pel_pkg;

    // Default number of code digits.
    localparam int CODE_DIGITS_DEFAULT = 4;

    // Field widths.
    localparam int TIMER_W = 20;
    localparam int HALVES_W = 4;
    localparam int FAIL_W = 4;
    localparam int KEY_W = 4;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W = 20;
    localparam int CODE_W = 16;
    localparam int WIDE_CODE_W = 32;

    // Fixed lamp timings in ticks.
    localparam logic [TIMER_W-1:0] DIGIT_FLASH_MS = 20'd80;
    localparam logic [TIMER_W-1:0] FULL_HALF_MS = 20'd100;
    localparam logic [HALVES_W-1:0] FULL_HALVES = 4'd4;
    localparam logic [HALVES_W-1:0] DENY_HALVES = 4'd12;
    localparam logic [FAIL_W-1:0] FAIL_MAX = 4'd15;

    // Key codes.
    localparam logic [KEY_W-1:0] KEY_LAST_DIGIT = 4'd9;
    localparam logic [KEY_W-1:0] KEY_STAR = 4'd10;
    localparam logic [KEY_W-1:0] KEY_HASH = 4'd11;
    localparam logic [KEY_W-1:0] KEY_LETTER_A = 4'd12;
    localparam logic [KEY_W-1:0] KEY_LETTER_D = 4'd15;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CORRECT_CODE  = 3'd0,
        REG_ATTEMPT_LIMIT = 3'd1,
        REG_LOCKOUT_MS    = 3'd2,
        REG_GRANTED_MS    = 3'd3,
        REG_DENY_HALF_MS  = 3'd4
    } reg_index_t;

    // Register reset values.
    localparam logic [15:0] CORRECT_CODE_RST = 16'h1234;
    localparam logic [3:0] ATTEMPT_LIMIT_RST = 4'd3;
    localparam logic [19:0] LOCKOUT_MS_RST = 20'd10000;
    localparam logic [15:0] GRANTED_MS_RST = 16'd3000;
    localparam logic [9:0] DENY_HALF_MS_RST = 10'd150;

    // Request kinds.
    typedef enum logic {
        REQ_KEY  = 1'b0,
        REQ_TICK = 1'b1
    } req_t;

    // Lamp phases.
    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_DIGIT = 3'd1,
        PH_FULL  = 3'd2,
        PH_GRANT = 3'd3,
        PH_DENY  = 3'd4,
        PH_LOCK  = 3'd5
    } phase_t;

    // Event codes reported with each result.
    typedef enum logic [3:0] {
        EV_NONE       = 4'd0,
        EV_DIGIT      = 4'd1,
        EV_FULL       = 4'd2,
        EV_CLEARED    = 4'd3,
        EV_GRANTED    = 4'd4,
        EV_DENIED     = 4'd5,
        EV_LOCK_START = 4'd6,
        EV_LOCK_END   = 4'd7,
        EV_UNUSED_KEY = 4'd8,
        EV_BUSY_DROP  = 4'd9
    } event_t;

    // Configuration register set.
    typedef struct packed {
        logic [15:0] correct_code;
        logic [3:0]  attempt_limit;
        logic [19:0] lockout_ms;
        logic [15:0] granted_ms;
        logic [9:0]  deny_half_ms;
    } cfg_t;

    // Control state other than the entry buffer.
    typedef struct packed {
        phase_t              phase;
        logic [TIMER_W-1:0]  timer;
        logic [HALVES_W-1:0] halves;
        logic [FAIL_W-1:0]   fail;
    } ctl_state_t;

    // One result without the digit count.
    typedef struct packed {
        logic              green_on;
        logic              red_on;
        logic              yellow_on;
        event_t            event_code;
        logic [FAIL_W-1:0] failures;
        logic              is_locked;
    } result_t;

endpackage

>>> hw/rtl/pel_core.sv
// ----------------------------------------------------------------------------
// PIN entry lock update logic
// Combinational next state and result for one key event or tick.
// ----------------------------------------------------------------------------
module pel_core #(
    parameter int CODE_DIGITS = pel_pkg::CODE_DIGITS_DEFAULT
) (
    input  pel_pkg::cfg_t                           cfg,
    input  pel_pkg::req_t                           req_type,
    input  logic [pel_pkg::KEY_W-1:0]               key_code,
    input  pel_pkg::ctl_state_t                     ctl_cur,
    input  logic [4*CODE_DIGITS-1:0]                digits_cur,
    input  logic [$clog2(CODE_DIGITS+1)-1:0]        count_cur,
    output pel_pkg::ctl_state_t                     ctl_next,
    output logic [4*CODE_DIGITS-1:0]                digits_next,
    output logic [$clog2(CODE_DIGITS+1)-1:0]        count_next,
    output pel_pkg::result_t                        result
);
    import pel_pkg::*;

    localparam int EW = 4 * CODE_DIGITS;
    localparam int CW = $clog2(CODE_DIGITS + 1);
    localparam logic [WIDE_CODE_W-1:0] CODE_MASK = {WIDE_CODE_W{1'b1}} >> (WIDE_CODE_W - EW);
    localparam logic [CW-1:0] FULL_COUNT = CW'(CODE_DIGITS);

    event_t              ev;
    logic [EW+3:0]       shifted;
    logic                code_ok;
    logic [TIMER_W-1:0]  timer_inc;
    logic [TIMER_W-1:0]  dur;
    logic [HALVES_W-1:0] halves_dec;
    logic                even_half;

    // Helper terms: shifted entry, code match, timer and blink countdown.
    assign shifted = {digits_cur, key_code};
    assign code_ok = (count_cur == FULL_COUNT) &&
                     (WIDE_CODE_W'(digits_cur) ==
                      (WIDE_CODE_W'(cfg.correct_code) & CODE_MASK));
    assign timer_inc = ctl_cur.timer + 1'b1;
    assign halves_dec = (ctl_cur.halves != '0) ? ctl_cur.halves - 1'b1 : '0;

    // Duration of the running phase.
    always_comb begin
        case (ctl_cur.phase)
            PH_DIGIT: dur = DIGIT_FLASH_MS;
            PH_FULL:  dur = FULL_HALF_MS;
            PH_GRANT: dur = TIMER_W'(cfg.granted_ms);
            PH_DENY:  dur = TIMER_W'(cfg.deny_half_ms);
            PH_LOCK:  dur = cfg.lockout_ms;
            default:  dur = '0;
        endcase
    end

    // Next state and event.
    always_comb begin
        ctl_next = ctl_cur;
        digits_next = digits_cur;
        count_next = count_cur;
        ev = EV_NONE;
        if (req_type == REQ_KEY) begin
            if (ctl_cur.phase != PH_IDLE) begin
                ev = EV_BUSY_DROP;
            end else if (key_code <= KEY_LAST_DIGIT) begin
                ctl_next.timer = '0;
                if (count_cur < FULL_COUNT) begin
                    digits_next = shifted[EW-1:0];
                    count_next = count_cur + 1'b1;
                    ctl_next.phase = PH_DIGIT;
                    ctl_next.halves = '0;
                    ev = EV_DIGIT;
                end else begin
                    ctl_next.phase = PH_FULL;
                    ctl_next.halves = FULL_HALVES;
                    ev = EV_FULL;
                end
            end else if (key_code == KEY_STAR) begin
                digits_next = '0;
                count_next = '0;
                ev = EV_CLEARED;
            end else if (key_code == KEY_HASH) begin
                digits_next = '0;
                count_next = '0;
                ctl_next.timer = '0;
                if (code_ok) begin
                    ctl_next.fail = '0;
                    ctl_next.phase = PH_GRANT;
                    ctl_next.halves = '0;
                    ev = EV_GRANTED;
                end else begin
                    if (ctl_cur.fail != FAIL_MAX) begin
                        ctl_next.fail = ctl_cur.fail + 1'b1;
                    end
                    ctl_next.phase = PH_DENY;
                    ctl_next.halves = DENY_HALVES;
                    ev = EV_DENIED;
                end
            end else begin
                ev = EV_UNUSED_KEY;
            end
        end else if (ctl_cur.phase != PH_IDLE) begin
            if (timer_inc < dur) begin
                ctl_next.timer = timer_inc;
            end else begin
                ctl_next.timer = '0;
                if (ctl_cur.phase == PH_FULL || ctl_cur.phase == PH_DENY) begin
                    ctl_next.halves = halves_dec;
                    if (halves_dec == '0) begin
                        if (ctl_cur.phase == PH_DENY && ctl_cur.fail >= cfg.attempt_limit) begin
                            ctl_next.phase = PH_LOCK;
                            ev = EV_LOCK_START;
                        end else begin
                            ctl_next.phase = PH_IDLE;
                        end
                    end
                end else if (ctl_cur.phase == PH_LOCK) begin
                    ctl_next.fail = '0;
                    digits_next = '0;
                    count_next = '0;
                    ctl_next.phase = PH_IDLE;
                    ctl_next.halves = '0;
                    ev = EV_LOCK_END;
                end else begin
                    ctl_next.phase = PH_IDLE;
                    ctl_next.halves = '0;
                end
            end
        end
    end

    // Lamp levels from the state after the update.
    always_comb begin
        even_half = !ctl_next.halves[0] && (ctl_next.halves != '0);
        result.green_on = (ctl_next.phase == PH_GRANT);
        result.red_on = (ctl_next.phase == PH_LOCK) ||
                        (ctl_next.phase == PH_DENY && even_half);
        result.yellow_on = (ctl_next.phase == PH_DIGIT) ||
                           (ctl_next.phase == PH_FULL && even_half);
        result.event_code = ev;
        result.failures = ctl_next.fail;
        result.is_locked = (ctl_next.phase == PH_LOCK);
    end

endmodule

>>> hw/rtl/pin_entry_lock_with_lockout.sv
// ----------------------------------------------------------------------------
// PIN entry lock with lockout
// Keypad code lock: digit entry, code check, timed lamps and failure lockout.
// ----------------------------------------------------------------------------
// Channel  | Direction | Contents
// s_       | in        | tuser: req_type; tdata[3:0]: key_code
// m_       | out       | tdata: green_on, red_on, yellow_on, event_code,
//          |           |        digits_entered, failures, is_locked
// cfg_     | in        | write enable, register index, write data
//
// An item is held in the input register; the state update and the result
// are formed while it is held there and land in the result register, so one
// item is taken per cycle while m_ does not stall. A stall on m_ holds
// the result and then the input register. Reset is synchronous on aresetn.
// ----------------------------------------------------------------------------
module pin_entry_lock_with_lockout #(
    parameter int CODE_DIGITS = pel_pkg::CODE_DIGITS_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [3:0] key_code
    input  logic                              s_tuser,   // [0] req_type
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [0] green_on, [1] red_on, [2] yellow_on, [6:3] event_code,
    // [9:7] digits_entered, [13:10] failures, [14] is_locked
    output logic [15:0]                       m_tdata,
    input  logic                              cfg_wr_en,
    input  logic [pel_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [pel_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import pel_pkg::*;

    `include "pin_entry_lock_with_lockout_macros.svh"

    localparam int EW = 4 * CODE_DIGITS;
    localparam int CW = $clog2(CODE_DIGITS + 1);

    cfg_t               cfg_reg;
    logic               in_valid_reg;
    req_t               in_type_reg;
    logic [KEY_W-1:0]   in_key_reg;
    logic               out_valid_reg;
    logic [15:0]        out_data_reg;
    ctl_state_t         ctl_reg;
    ctl_state_t         ctl_next;
    logic [EW-1:0]      digits_reg;
    logic [EW-1:0]      digits_next;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    result_t            result;
    logic [2:0]         count_out;
    logic               advance;
    logic               in_take;
    logic               blink_phase;

    // Pipeline handshake: the item moves on when the result slot frees up.
    assign advance = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_take = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_data_reg;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.correct_code <= CORRECT_CODE_RST;
            cfg_reg.attempt_limit <= ATTEMPT_LIMIT_RST;
            cfg_reg.lockout_ms <= LOCKOUT_MS_RST;
            cfg_reg.granted_ms <= GRANTED_MS_RST;
            cfg_reg.deny_half_ms <= DENY_HALF_MS_RST;
        end else if (cfg_wr_en) begin
            case (reg_index_t'(cfg_index))
                REG_CORRECT_CODE:  cfg_reg.correct_code <= cfg_wdata[15:0];
                REG_ATTEMPT_LIMIT: cfg_reg.attempt_limit <= cfg_wdata[3:0];
                REG_LOCKOUT_MS:    cfg_reg.lockout_ms <= cfg_wdata;
                REG_GRANTED_MS:    cfg_reg.granted_ms <= cfg_wdata[15:0];
                REG_DENY_HALF_MS:  cfg_reg.deny_half_ms <= cfg_wdata[9:0];
                default: ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_type_reg <= req_t'(s_tuser);
            in_key_reg <= s_tdata[KEY_W-1:0];
        end
    end

    // Update logic for the held item.
    pel_core #(
        .CODE_DIGITS(CODE_DIGITS)
    ) u_core (
        .cfg        (cfg_reg),
        .req_type   (in_type_reg),
        .key_code   (in_key_reg),
        .ctl_cur    (ctl_reg),
        .digits_cur (digits_reg),
        .count_cur  (count_reg),
        .ctl_next   (ctl_next),
        .digits_next(digits_next),
        .count_next (count_next),
        .result     (result)
    );

    assign count_out = 3'(count_next);

    // Lock state, committed when the item transfers into the result slot.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg.phase <= PH_IDLE;
            ctl_reg.timer <= '0;
            ctl_reg.halves <= '0;
            ctl_reg.fail <= '0;
            digits_reg <= '0;
            count_reg <= '0;
        end else if (advance) begin
            ctl_reg <= ctl_next;
            digits_reg <= digits_next;
            count_reg <= count_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= {1'b0, result.is_locked, result.failures, count_out,
                             result.event_code, result.yellow_on, result.red_on,
                             result.green_on};
        end
    end

    // Checks on the lock state and the pipeline.
    assign blink_phase = (ctl_reg.phase == PH_FULL) || (ctl_reg.phase == PH_DENY);

    `PEL_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CW'(CODE_DIGITS), "entry count over limit")
    `PEL_ASSERT_NOW(a_blink_live, blink_phase, ctl_reg.halves != '0, "blink with no halves left")
    `PEL_ASSERT_NOW(a_steady_phase, !blink_phase, ctl_reg.halves == '0, "stray blink count")
    `PEL_ASSERT_NEXT(a_result_follows, advance, out_valid_reg, "moved item left no result")

endmodule

>>> tb/pin_entry_lock_checker.sv
// ----------------------------------------------------------------------------
// PIN entry lock report checker
// Watches the key/tick channel and the configuration port, predicts the lamp
// report that each accepted transfer must produce, and compares every report
// leaving the block with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pin_entry_lock_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [7:0]                      s_tdata,    // [3:0] key_code
    input  logic                            s_tuser,    // [0] req_type
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    // [0] green_on, [1] red_on, [2] yellow_on, [6:3] event_code,
    // [9:7] digits_entered, [13:10] failures, [14] is_locked
    input  logic [15:0]                     m_tdata,
    input  logic                            cfg_wr_en,
    input  logic [pel_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [pel_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output int                              report_errors,
    output int                              reports_pending
);
    import pel_pkg::*;

    localparam int ENTRY_DIGITS = CODE_DIGITS_DEFAULT;

    // One lamp report, laid out as on m_tdata (first member is the top bit).
    typedef struct packed {
        logic              is_locked;
        logic [FAIL_W-1:0] failures;
        logic [2:0]        digits_entered;
        event_t            event_code;
        logic              yellow_on;
        logic              red_on;
        logic              green_on;
    } lamp_report_t;

    // Predicted lock state and register copy.
    cfg_t                lock_cfg;
    logic [15:0]         entry_bcd;
    logic [2:0]          entry_len;
    logic [FAIL_W-1:0]   fail_cnt;
    phase_t              lamp_phase;
    logic [TIMER_W-1:0]  lamp_timer;
    logic [HALVES_W-1:0] halves_left;

    lamp_report_t pending_reports[$];

    initial begin
        report_errors = 0;
        reports_pending = 0;
    end

    // Enter a lamp phase with a fresh timer.
    task automatic enter_phase(input phase_t ph, input logic [HALVES_W-1:0] halves);
        lamp_phase = ph;
        lamp_timer = '0;
        halves_left = halves;
    endtask

    // Apply one key press or one millisecond tick and form the lamp report.
    task automatic advance_lock(input req_t kind, input logic [3:0] key,
                                output lamp_report_t rep);
        event_t             ev;
        logic [TIMER_W-1:0] dur;
        logic               even_half;
        logic               code_ok;
        ev = EV_NONE;
        if (kind == REQ_TICK) begin
            case (lamp_phase)
                PH_DIGIT: dur = DIGIT_FLASH_MS;
                PH_FULL:  dur = FULL_HALF_MS;
                PH_GRANT: dur = TIMER_W'(lock_cfg.granted_ms);
                PH_DENY:  dur = TIMER_W'(lock_cfg.deny_half_ms);
                PH_LOCK:  dur = lock_cfg.lockout_ms;
                default:  dur = '0;
            endcase
            // A zero duration ends the phase on the first tick, like one.
            if (lamp_phase != PH_IDLE) begin
                lamp_timer = lamp_timer + 1'b1;
                if (lamp_timer >= dur) begin
                    lamp_timer = '0;
                    if (lamp_phase == PH_FULL || lamp_phase == PH_DENY) begin
                        if (halves_left != '0)
                            halves_left = halves_left - 1'b1;
                        if (halves_left == '0) begin
                            if (lamp_phase == PH_DENY &&
                                fail_cnt >= lock_cfg.attempt_limit) begin
                                enter_phase(PH_LOCK, '0);
                                ev = EV_LOCK_START;
                            end else begin
                                enter_phase(PH_IDLE, '0);
                            end
                        end
                    end else if (lamp_phase == PH_LOCK) begin
                        fail_cnt = '0;
                        entry_bcd = '0;
                        entry_len = '0;
                        enter_phase(PH_IDLE, '0);
                        ev = EV_LOCK_END;
                    end else begin
                        enter_phase(PH_IDLE, '0);
                    end
                end
            end
        end else if (lamp_phase != PH_IDLE) begin
            // Keys are dropped while any lamp phase or the lockout runs.
            ev = EV_BUSY_DROP;
        end else if (key <= KEY_LAST_DIGIT) begin
            if (entry_len < ENTRY_DIGITS) begin
                entry_bcd = {entry_bcd[11:0], key};
                entry_len = entry_len + 1'b1;
                enter_phase(PH_DIGIT, '0);
                ev = EV_DIGIT;
            end else begin
                enter_phase(PH_FULL, FULL_HALVES);
                ev = EV_FULL;
            end
        end else if (key == KEY_STAR) begin
            entry_bcd = '0;
            entry_len = '0;
            ev = EV_CLEARED;
        end else if (key == KEY_HASH) begin
            // Only a full buffer equal to the code grants; anything else fails.
            code_ok = (entry_len == ENTRY_DIGITS) && (entry_bcd == lock_cfg.correct_code);
            entry_bcd = '0;
            entry_len = '0;
            if (code_ok) begin
                fail_cnt = '0;
                enter_phase(PH_GRANT, '0);
                ev = EV_GRANTED;
            end else begin
                if (fail_cnt != FAIL_MAX)
                    fail_cnt = fail_cnt + 1'b1;
                enter_phase(PH_DENY, DENY_HALVES);
                ev = EV_DENIED;
            end
        end else begin
            ev = EV_UNUSED_KEY;
        end

        even_half = (halves_left[0] == 1'b0) && (halves_left != '0);
        rep.green_on = (lamp_phase == PH_GRANT);
        rep.red_on = (lamp_phase == PH_LOCK) || (lamp_phase == PH_DENY && even_half);
        rep.yellow_on = (lamp_phase == PH_DIGIT) || (lamp_phase == PH_FULL && even_half);
        rep.event_code = ev;
        rep.digits_entered = entry_len;
        rep.failures = fail_cnt;
        rep.is_locked = (lamp_phase == PH_LOCK);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            if (report_errors < 10)
                $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            report_errors++;
        end
    endtask

    // Channel monitor: reports are checked before new predictions are queued,
    // since no transfer can come out in the cycle it goes in.
    always @(posedge aclk) begin : watch
        lamp_report_t got;
        lamp_report_t want;
        if (!aresetn) begin
            lock_cfg.correct_code = CORRECT_CODE_RST;
            lock_cfg.attempt_limit = ATTEMPT_LIMIT_RST;
            lock_cfg.lockout_ms = LOCKOUT_MS_RST;
            lock_cfg.granted_ms = GRANTED_MS_RST;
            lock_cfg.deny_half_ms = DENY_HALF_MS_RST;
            entry_bcd = '0;
            entry_len = '0;
            fail_cnt = '0;
            enter_phase(PH_IDLE, '0);
            pending_reports.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = lamp_report_t'(m_tdata[14:0]);
                if (pending_reports.size() == 0) begin
                    if (report_errors < 10)
                        $display("%0t ns: report %h with nothing expected", $time, m_tdata);
                    report_errors++;
                end else begin
                    want = pending_reports.pop_front();
                    check_field("green_on", want.green_on, got.green_on);
                    check_field("red_on", want.red_on, got.red_on);
                    check_field("yellow_on", want.yellow_on, got.yellow_on);
                    check_field("event_code", want.event_code, got.event_code);
                    check_field("digits_entered", want.digits_entered, got.digits_entered);
                    check_field("failures", want.failures, got.failures);
                    check_field("is_locked", want.is_locked, got.is_locked);
                end
            end

            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_CORRECT_CODE:  lock_cfg.correct_code = cfg_wdata[15:0];
                    REG_ATTEMPT_LIMIT: lock_cfg.attempt_limit = cfg_wdata[3:0];
                    REG_LOCKOUT_MS:    lock_cfg.lockout_ms = cfg_wdata[19:0];
                    REG_GRANTED_MS:    lock_cfg.granted_ms = cfg_wdata[15:0];
                    REG_DENY_HALF_MS:  lock_cfg.deny_half_ms = cfg_wdata[9:0];
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready) begin
                advance_lock(req_t'(s_tuser), s_tdata[3:0], want);
                pending_reports.push_back(want);
            end
        end
        reports_pending = pending_reports.size();
    end

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// PIN entry lock testbench
// Drives key presses and millisecond ticks into the lock under several
// register settings and back-pressure patterns; the report checker beside
// the block predicts and compares every lamp report.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import pel_pkg::*;

    localparam int HOLD_CYCLES = 60;
    localparam int NOISE_ITEMS = 60;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata = '0;    // [3:0] key_code
    logic                   s_tuser = 1'b0;  // [0] req_type
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // [0] green_on, [1] red_on, [2] yellow_on, [6:3] event_code,
    // [9:7] digits_entered, [13:10] failures, [14] is_locked
    logic [15:0]            m_tdata;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    int   report_errors;
    int   reports_pending;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    logic hold_rx = 1'b0;
    event hold_start;

    always #10 aclk = ~aclk;

    pin_entry_lock_with_lockout dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    pin_entry_lock_checker lock_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .report_errors   (report_errors),
        .reports_pending (reports_pending)
    );

    // Report sink: random stalls, forced low during a long hold.
    always @(negedge aclk) begin
        m_tready <= !hold_rx && ($urandom_range(99) >= recv_idle_pct);
    end

    // Long receiver hold, counted here so the sender keeps offering transfers.
    initial begin
        forever begin
            @(hold_start);
            @(posedge aclk);
            hold_rx <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge aclk);
            hold_rx <= 1'b0;
        end
    end

    // Run watchdog, far beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("[pin_entry_lock_with_lockout] ERROR");
        $finish;
    end

    // Offer one transfer; called and returning at a falling edge.
    task automatic push_item(input req_t kind, input logic [3:0] key);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {4'b0000, key};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic send_ticks(input int n);
        int i;
        for (i = 0; i < n; i++)
            push_item(REQ_TICK, 4'($urandom_range(15)));
    endtask

    task automatic press(input logic [3:0] key, input int ticks);
        push_item(REQ_KEY, key);
        send_ticks(ticks);
    endtask

    // Random mix of keys and ticks.
    task automatic send_noise(input int n);
        int i;
        for (i = 0; i < n; i++)
            push_item(req_t'($urandom_range(1)), 4'($urandom_range(15)));
    endtask

    // Sender pause until every report has come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        wait (reports_pending == 0);
        repeat (3) @(negedge aclk);
    endtask

    // Write all five registers in back-to-back cycles; the block is idle.
    task automatic apply_settings(input cfg_t c);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_CORRECT_CODE;
        cfg_wdata <= CFG_DATA_W'(c.correct_code);
        @(negedge aclk);
        cfg_index <= REG_ATTEMPT_LIMIT;
        cfg_wdata <= CFG_DATA_W'(c.attempt_limit);
        @(negedge aclk);
        cfg_index <= REG_LOCKOUT_MS;
        cfg_wdata <= c.lockout_ms;
        @(negedge aclk);
        cfg_index <= REG_GRANTED_MS;
        cfg_wdata <= CFG_DATA_W'(c.granted_ms);
        @(negedge aclk);
        cfg_index <= REG_DENY_HALF_MS;
        cfg_wdata <= CFG_DATA_W'(c.deny_half_ms);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Short timings so that phases end within the noise; mostly a BCD code.
    function automatic cfg_t random_settings();
        cfg_t c;
        c.correct_code = {4'($urandom_range(9)), 4'($urandom_range(9)),
                          4'($urandom_range(9)), 4'($urandom_range(9))};
        if ($urandom_range(7) == 0)
            c.correct_code = 16'($urandom);
        c.attempt_limit = 4'($urandom_range(1, 4));
        c.lockout_ms = 20'($urandom_range(1, 40));
        c.granted_ms = 16'($urandom_range(1, 40));
        c.deny_half_ms = 10'($urandom_range(1, 6));
        return c;
    endfunction

    initial begin
        cfg_t c;
        int   wait_cycles;

        // Reset, then the directed settings.
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        c.correct_code = 16'h1234;
        c.attempt_limit = 4'd2;
        c.lockout_ms = 20'd6;
        c.granted_ms = 16'd4;
        c.deny_half_ms = 10'd2;
        apply_settings(c);

        // Sender idles lightly, receiver heavily, with one long hold.
        send_idle_pct = 8;
        recv_idle_pct = 61;
        -> hold_start;

        // Idle tick, unused letters, clear, empty confirm, entry with a busy
        // drop, overfull digit, grant and a drop during the green time.
        push_item(REQ_TICK, 4'd0);
        press(KEY_LETTER_A, 0);
        press(KEY_LETTER_D, 0);
        press(KEY_STAR, 0);
        press(KEY_HASH, 24);
        push_item(REQ_KEY, 4'd1);
        press(4'd7, DIGIT_FLASH_MS);
        press(4'd2, DIGIT_FLASH_MS);
        press(4'd3, DIGIT_FLASH_MS);
        press(4'd4, DIGIT_FLASH_MS);
        press(4'd9, 4 * FULL_HALF_MS);
        push_item(REQ_KEY, KEY_HASH);
        press(4'd5, 4);
        drain();

        // Sender idles heavily, receiver lightly: denials into a lockout.
        send_idle_pct = 61;
        recv_idle_pct = 8;
        press(4'd9, DIGIT_FLASH_MS);
        press(KEY_HASH, 24);
        press(KEY_HASH, 24);
        press(KEY_HASH, 3);
        press(4'd8, 3);
        drain();
        apply_settings(random_settings());
        send_noise(NOISE_ITEMS);
        drain();

        // No idling: smallest register values, short entry against code 0000.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        c.correct_code = 16'h0000;
        c.attempt_limit = 4'd1;
        c.lockout_ms = 20'd1;
        c.granted_ms = 16'd1;
        c.deny_half_ms = 10'd1;
        apply_settings(c);
        press(4'd0, DIGIT_FLASH_MS);
        press(KEY_HASH, 13);
        press(KEY_HASH, 13);
        drain();
        apply_settings(random_settings());
        send_noise(NOISE_ITEMS);
        drain();

        // Largest register values: the start of the longest blink.
        c.correct_code = 16'hFFFF;
        c.attempt_limit = 4'd15;
        c.lockout_ms = 20'hFFFFF;
        c.granted_ms = 16'hFFFF;
        c.deny_half_ms = 10'h3FF;
        apply_settings(c);
        press(KEY_HASH, 40);

        // Let the last reports come out, then give the verdict.
        s_tvalid <= 1'b0;
        for (wait_cycles = 0; wait_cycles < 1000 && reports_pending != 0; wait_cycles++)
            @(negedge aclk);
        repeat (10) @(negedge aclk);
        if (report_errors == 0 && reports_pending == 0) begin
            $display("[pin_entry_lock_with_lockout] OK");
        end else begin
            $display("[pin_entry_lock_with_lockout] ERROR");
        end
        $finish;
    end

endmodule
